// ----- hdl/adjacency_matrix_graph_store_top_macros.svh -----
// Assertion macros for the adjacency matrix graph store top level.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AMG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/amg_pkg.sv -----
// Shared constants, codes and types of the adjacency matrix graph store.
package amg_pkg;

  // Default node capacity.
  localparam int NODE_CAP_DEF = 64;

  // Field widths of the request, response and configuration channels.
  localparam int ACT_W   = 4;
  localparam int NODE_W  = 6;
  localparam int STAT_W  = 2;
  localparam int LIMIT_W = 7;

  // Reset value of the node limit register.
  localparam logic [LIMIT_W-1:0] NODE_LIMIT_RST = 7'd64;

  // Request actions.
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_NODE   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_ADD_EDGE   = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SET_SEEN   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY_SEEN = 4'd4;
  localparam logic [ACT_W-1:0] ACT_RESET_SEEN = 4'd5;
  localparam logic [ACT_W-1:0] ACT_NEIGHBOURS = 4'd6;
  localparam logic [ACT_W-1:0] ACT_IS_EMPTY   = 4'd7;
  localparam logic [ACT_W-1:0] ACT_HAS_EDGES  = 4'd8;

  // Response status codes.
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

  // Commands from the controller to the neighbour scanner.
  typedef struct packed {
    logic load;
    logic shift;
  } scan_ctl_t;

  // Status of the neighbour scanner.
  typedef struct packed {
    logic              hit;
    logic              rest_zero;
    logic              empty;
    logic [NODE_W-1:0] idx;
  } scan_stat_t;

endpackage

// ----- hdl/amg_req_if.sv -----
// Request channel carrying one graph action.
interface amg_req_if;
  logic                        valid;
  logic                        ready;
  logic [amg_pkg::ACT_W-1:0]   action;
  logic [amg_pkg::NODE_W-1:0]  node_a;
  logic [amg_pkg::NODE_W-1:0]  node_b;
  logic                        seen_value;

  modport source (output valid, action, node_a, node_b, seen_value, input ready);
  modport sink   (input valid, action, node_a, node_b, seen_value, output ready);
endinterface

// ----- hdl/amg_rsp_if.sv -----
// Response channel carrying one result of a graph action.
interface amg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [amg_pkg::STAT_W-1:0]  status;
  logic                        answer_flag;
  logic [amg_pkg::NODE_W-1:0]  node_index;
  logic                        index_valid;
  logic                        last;

  modport source (output valid, status, answer_flag, node_index, index_valid, last,
                  input ready);
  modport sink   (input valid, status, answer_flag, node_index, index_valid, last,
                  output ready);
endinterface

// ----- hdl/amg_cfg_if.sv -----
// Configuration write channel for the node limit register.
interface amg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [amg_pkg::LIMIT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/amg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module amg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/amg_nbr_scan.sv -----
// Neighbour scanner: walks one adjacency row from the highest index down.
module amg_nbr_scan #(
  parameter int NODE_CAP = amg_pkg::NODE_CAP_DEF
) (
  input  logic                clk,
  input  amg_pkg::scan_ctl_t  ctl,
  input  logic [NODE_CAP-1:0] row_i,
  output amg_pkg::scan_stat_t stat
);

  localparam int AW = $clog2(NODE_CAP);

  logic [NODE_CAP-1:0] row_r;
  logic [NODE_CAP-1:0] row_nxt;
  logic [AW-1:0]       idx_r;
  logic [AW-1:0]       idx_nxt;

  // Load a fresh row, or step one bit lower per shift.
  always_comb begin
    row_nxt = row_r;
    idx_nxt = idx_r;
    if (ctl.load) begin
      row_nxt = row_i;
      idx_nxt = AW'(NODE_CAP - 1);
    end else if (ctl.shift) begin
      row_nxt = row_r << 1;
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    idx_r <= idx_nxt;
  end

  // The top bit of the shifted row belongs to the index in idx_r.
  assign stat.hit       = row_r[NODE_CAP-1];
  assign stat.rest_zero = (row_r[NODE_CAP-2:0] == '0);
  assign stat.empty     = (row_r == '0);
  assign stat.idx       = amg_pkg::NODE_W'(idx_r);

endmodule

// ----- hdl/adjacency_matrix_graph_store_top.sv -----
// Top level of the adjacency matrix graph store: control, state memories and result register.
// Flow: a request is latched while idle, as the memories read its node, then executes in the
// exec state and its result is registered. A neighbour listing loads the scanner, which tests
// one row bit per cycle unless a hit waits on a full result register. No new request is taken
// until the last result is formed; a full result register stalls the block until it is taken.
// Reset clears node count, edge and seen valid bits and restores node_limit to 64; no sweep.
`include "adjacency_matrix_graph_store_top_macros.svh"

module adjacency_matrix_graph_store_top #(
  parameter int NODE_CAP = amg_pkg::NODE_CAP_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  amg_req_if.sink      in_req,
  amg_rsp_if.source    out_rsp,
  amg_cfg_if.sink      cfg_wr
);

  localparam int AW = $clog2(NODE_CAP);
  localparam int CW = $clog2(NODE_CAP + 1);
  localparam logic [amg_pkg::LIMIT_W-1:0] MAX_LIM = amg_pkg::LIMIT_W'(NODE_CAP);
  localparam logic [NODE_CAP-1:0] ROW_ONE = {{(NODE_CAP-1){1'b0}}, 1'b1};

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Latched request.
  logic [amg_pkg::ACT_W-1:0]  act_r;
  logic [amg_pkg::NODE_W-1:0] a_r;
  logic [amg_pkg::NODE_W-1:0] b_r;
  logic                       sv_r;

  // Graph bookkeeping.
  logic [amg_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               cnt_nxt;
  logic                        any_edge_r;
  logic                        any_edge_nxt;
  logic [NODE_CAP-1:0]         row_vld_r;
  logic [NODE_CAP-1:0]         row_vld_nxt;
  logic [NODE_CAP-1:0]         seen_vld_r;
  logic [NODE_CAP-1:0]         seen_vld_nxt;

  // Memory ports.
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       a_idx;
  logic [NODE_CAP-1:0] edge_rdata;
  logic [NODE_CAP-1:0] edge_wdata;
  logic                edge_we;
  logic                seen_rdata;
  logic                seen_we;

  // Result register.
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [amg_pkg::STAT_W-1:0]  res_stat_r;
  logic                        res_flag_r;
  logic [amg_pkg::NODE_W-1:0]  res_idx_r;
  logic                        res_ivld_r;
  logic                        res_last_r;
  logic [amg_pkg::STAT_W-1:0]  res_stat;
  logic                        res_flag;
  logic [amg_pkg::NODE_W-1:0]  res_idx;
  logic                        res_ivld;
  logic                        res_last;
  logic                        emit;

  // Derived conditions.
  logic                        in_acc;
  logic                        slot_free;
  logic                        a_ok;
  logic                        b_ok;
  logic                        room;
  logic [amg_pkg::LIMIT_W-1:0] lim_act;
  logic [NODE_CAP-1:0]         row_cur;
  logic                        seen_cur;

  amg_pkg::scan_ctl_t  scan_ctl;
  amg_pkg::scan_stat_t scan_stat;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_rsp.ready;

  // Read at the incoming node while idle, then hold the latched node.
  assign rd_addr = (state_r == ST_IDLE) ? in_req.node_a[AW-1:0] : a_r[AW-1:0];
  assign a_idx   = a_r[AW-1:0];

  // Entries not written since their valid bit was last cleared read as zero.
  assign row_cur  = row_vld_r[a_idx] ? edge_rdata : '0;
  assign seen_cur = seen_vld_r[a_idx] & seen_rdata;

  assign lim_act    = (limit_r > MAX_LIM) ? MAX_LIM : limit_r;
  assign a_ok       = amg_pkg::LIMIT_W'(a_r) < amg_pkg::LIMIT_W'(cnt_r);
  assign b_ok       = amg_pkg::LIMIT_W'(b_r) < amg_pkg::LIMIT_W'(cnt_r);
  assign room       = amg_pkg::LIMIT_W'(cnt_r) < lim_act;
  assign edge_wdata = row_cur | (ROW_ONE << b_r[AW-1:0]);

  // Adjacency rows, one per source node.
  amg_ram #(
    .WIDTH (NODE_CAP),
    .DEPTH (NODE_CAP)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (a_idx),
    .wdata (edge_wdata),
    .raddr (rd_addr),
    .rdata (edge_rdata)
  );

  // Seen flags, one per node.
  amg_ram #(
    .WIDTH (1),
    .DEPTH (NODE_CAP)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (a_idx),
    .wdata (sv_r),
    .raddr (rd_addr),
    .rdata (seen_rdata)
  );

  amg_nbr_scan #(
    .NODE_CAP (NODE_CAP)
  ) u_nbr_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .row_i (row_cur),
    .stat  (scan_stat)
  );

  // Controller: execute one action, or step the neighbour scan.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    any_edge_nxt = any_edge_r;
    row_vld_nxt  = row_vld_r;
    seen_vld_nxt = seen_vld_r;
    edge_we      = 1'b0;
    seen_we      = 1'b0;
    scan_ctl     = '0;
    emit         = 1'b0;
    res_stat     = amg_pkg::STAT_OK;
    res_flag     = 1'b0;
    res_idx      = '0;
    res_ivld     = 1'b0;
    res_last     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          unique case (act_r)
            amg_pkg::ACT_CLEAR: begin
              row_vld_nxt  = '0;
              seen_vld_nxt = '0;
              cnt_nxt      = '0;
              any_edge_nxt = 1'b0;
            end
            amg_pkg::ACT_ADD_NODE: begin
              if (!room) begin
                res_stat = amg_pkg::STAT_FULL;
              end else begin
                seen_vld_nxt[cnt_r[AW-1:0]] = 1'b0;
                res_idx  = amg_pkg::NODE_W'(cnt_r);
                res_ivld = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            amg_pkg::ACT_ADD_EDGE: begin
              if (!a_ok || !b_ok) begin
                res_stat = amg_pkg::STAT_ABSENT;
              end else begin
                edge_we            = 1'b1;
                row_vld_nxt[a_idx] = 1'b1;
                any_edge_nxt       = 1'b1;
              end
            end
            amg_pkg::ACT_SET_SEEN: begin
              if (!a_ok) begin
                res_stat = amg_pkg::STAT_ABSENT;
              end else begin
                seen_we             = 1'b1;
                seen_vld_nxt[a_idx] = 1'b1;
              end
            end
            amg_pkg::ACT_QUERY_SEEN: begin
              if (!a_ok) begin
                res_stat = amg_pkg::STAT_ABSENT;
              end else begin
                res_flag = seen_cur;
              end
            end
            amg_pkg::ACT_RESET_SEEN: begin
              seen_vld_nxt = '0;
            end
            amg_pkg::ACT_NEIGHBOURS: begin
              if (!a_ok) begin
                res_stat = amg_pkg::STAT_ABSENT;
              end else if (row_cur != '0) begin
                // Results come from the scanner instead.
                emit          = 1'b0;
                scan_ctl.load = 1'b1;
                state_nxt     = ST_SCAN;
              end
            end
            amg_pkg::ACT_IS_EMPTY: begin
              res_flag = (cnt_r == '0);
            end
            amg_pkg::ACT_HAS_EDGES: begin
              res_flag = any_edge_r;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_stat.hit) begin
          scan_ctl.shift = 1'b1;
        end else if (slot_free) begin
          emit           = 1'b1;
          res_idx        = scan_stat.idx;
          res_ivld       = 1'b1;
          res_last       = scan_stat.rest_zero;
          scan_ctl.shift = 1'b1;
          if (scan_stat.rest_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register handshake.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      any_edge_r  <= 1'b0;
      row_vld_r   <= '0;
      seen_vld_r  <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= amg_pkg::NODE_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      any_edge_r  <= any_edge_nxt;
      row_vld_r   <= row_vld_nxt;
      seen_vld_r  <= seen_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        limit_r <= cfg_wr.data;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_req.action;
      a_r   <= in_req.node_a;
      b_r   <= in_req.node_b;
      sv_r  <= in_req.seen_value;
    end
    if (emit) begin
      res_stat_r <= res_stat;
      res_flag_r <= res_flag;
      res_idx_r  <= res_idx;
      res_ivld_r <= res_ivld;
      res_last_r <= res_last;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = res_stat_r;
  assign out_rsp.answer_flag = res_flag_r;
  assign out_rsp.node_index  = res_idx_r;
  assign out_rsp.index_valid = res_ivld_r;
  assign out_rsp.last        = res_last_r;

  // Checks on the controller.
  `AMG_ASSERT_SAME(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(NODE_CAP), "node count over capacity")
  `AMG_ASSERT_NEXT(a_cnt_step, clk, rst_n, 1'b1, (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1) || (cnt_r == '0), "node count jumped")
  `AMG_ASSERT_SAME(a_scan_row, clk, rst_n, state_r == ST_SCAN, !scan_stat.empty, "scan on an empty row")
  `AMG_ASSERT_SAME(a_emit_slot, clk, rst_n, emit, !out_valid_r || out_rsp.ready, "result overwrote a pending result")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the adjacency matrix graph store, with directed and random requests.
`timescale 1ns / 100ps

module tb_top;
  import amg_pkg::*;

  localparam int NODES = NODE_CAP_DEF;

  // Actions above has-edges are spare codes that the block must answer with a bare last.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd9;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;

  localparam int IDLE_PCT    = 13;
  localparam int HOLD_AFTER  = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              seen_value;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              answer_flag;
    logic [NODE_W-1:0] node_index;
    logic              index_valid;
    logic              last;
  } result_t;

  // Graph model that predicts each result and holds the ones still to arrive.
  class graph_scoreboard;
    bit [NODES-1:0]   edge_rows [NODES];
    bit [NODES-1:0]   seen_bits;
    bit [LIMIT_W-1:0] node_count;
    bit [LIMIT_W-1:0] node_limit;
    result_t          pending_results [$];
    int unsigned      errors;

    function new();
      clear_graph();
      node_limit = NODE_LIMIT_RST;
      errors = 0;
    endfunction

    function void clear_graph();
      foreach (edge_rows[i]) edge_rows[i] = '0;
      seen_bits = '0;
      node_count = '0;
    endfunction

    function void push_result(logic [STAT_W-1:0] status, logic flag, logic [NODE_W-1:0] idx,
                              logic idx_ok, logic last);
      result_t r;
      r.status      = status;
      r.answer_flag = flag;
      r.node_index  = idx;
      r.index_valid = idx_ok;
      r.last        = last;
      pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the graph and queue the results it causes.
    function void note_request(request_t r);
      bit               a_ok;
      bit               b_ok;
      bit               any;
      bit [LIMIT_W-1:0] cap;
      bit [NODES-1:0]   row;
      a_ok = r.node_a < node_count;
      b_ok = r.node_b < node_count;
      cap = (node_limit > NODES) ? LIMIT_W'(NODES) : node_limit;
      case (r.action)
        ACT_CLEAR: begin
          clear_graph();
          push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
        end
        ACT_ADD_NODE: begin
          if (node_count >= cap) begin
            push_result(STAT_FULL, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            seen_bits[node_count[NODE_W-1:0]] = 1'b0;
            push_result(STAT_OK, 1'b0, node_count[NODE_W-1:0], 1'b1, 1'b1);
            node_count++;
          end
        end
        ACT_ADD_EDGE: begin
          if (!a_ok || !b_ok) begin
            push_result(STAT_ABSENT, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            edge_rows[r.node_a][r.node_b] = 1'b1;
            push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        ACT_SET_SEEN: begin
          if (!a_ok) begin
            push_result(STAT_ABSENT, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            seen_bits[r.node_a] = r.seen_value;
            push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
          end
        end
        ACT_QUERY_SEEN: begin
          if (!a_ok) push_result(STAT_ABSENT, 1'b0, '0, 1'b0, 1'b1);
          else push_result(STAT_OK, seen_bits[r.node_a], '0, 1'b0, 1'b1);
        end
        ACT_RESET_SEEN: begin
          seen_bits = '0;
          push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
        end
        ACT_NEIGHBOURS: begin
          // Neighbours come out from the highest index down; last marks the lowest one.
          row = edge_rows[r.node_a];
          if (!a_ok) begin
            push_result(STAT_ABSENT, 1'b0, '0, 1'b0, 1'b1);
          end else if (row == '0) begin
            push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
          end else begin
            for (int i = NODES - 1; i >= 0; i--) begin
              if (row[i]) begin
                push_result(STAT_OK, 1'b0, NODE_W'(i), 1'b1, (row << (NODES - i)) == '0);
              end
            end
          end
        end
        ACT_IS_EMPTY: begin
          push_result(STAT_OK, node_count == 0, '0, 1'b0, 1'b1);
        end
        ACT_HAS_EDGES: begin
          any = 1'b0;
          foreach (edge_rows[j]) any |= |edge_rows[j];
          push_result(STAT_OK, any, '0, 1'b0, 1'b1);
        end
        default: begin
          push_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    // Compare one taken result with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d node_index %0d last %0b",
               got.status, got.node_index, got.last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.answer_flag !== want.answer_flag) begin
        $error("answer_flag: expected %0b, actual %0b", want.answer_flag, got.answer_flag);
        errors++;
      end
      if (got.node_index !== want.node_index) begin
        $error("node_index: expected %0d, actual %0d", want.node_index, got.node_index);
        errors++;
      end
      if (got.index_valid !== want.index_valid) begin
        $error("index_valid: expected %0b, actual %0b", want.index_valid, got.index_valid);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  bit              steady = 1'b0;
  int unsigned     results_taken = 0;
  graph_scoreboard sb;

  amg_req_if req_ch();
  amg_rsp_if rsp_ch();
  amg_cfg_if cfg_ch();

  adjacency_matrix_graph_store_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("FAIL adjacency_matrix_graph_store_top");
    $finish;
  end

  // Result side: take results with random stalls and one long hold-off to back the block up.
  initial begin : result_sink
    int      hold_left;
    bit      held;
    result_t got;
    hold_left = 0;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.status      = rsp_ch.status;
        got.answer_flag = rsp_ch.answer_flag;
        got.node_index  = rsp_ch.node_index;
        got.index_valid = rsp_ch.index_valid;
        got.last        = rsp_ch.last;
        sb.check_result(got);
        results_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!held && results_taken >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request, possibly after a short gap, and note it once it is taken.
  task automatic send_request(logic [ACT_W-1:0] action, logic [NODE_W-1:0] node_a,
                              logic [NODE_W-1:0] node_b, logic seen_value);
    request_t r;
    r.action     = action;
    r.node_a     = node_a;
    r.node_b     = node_b;
    r.seen_value = seen_value;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= action;
    req_ch.node_a     <= node_a;
    req_ch.node_b     <= node_b;
    req_ch.seen_value <= seen_value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
  endtask

  // Stop offering requests and wait until every predicted result has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the node limit while the block is idle.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.node_limit = value;
  endtask

  // Mostly indices of present nodes, sometimes the first absent one, sometimes anything.
  function automatic logic [NODE_W-1:0] pick_node();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sb.node_count != 0 && roll < 88) return NODE_W'($urandom_range(0, sb.node_count - 1));
    if (roll < 94 && sb.node_count < NODES) return sb.node_count[NODE_W-1:0];
    return NODE_W'($urandom_range(0, NODES - 1));
  endfunction

  // Random requests weighted toward graph building and neighbour listings.
  task automatic run_random(int n);
    int unsigned      pick;
    logic [ACT_W-1:0] action;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      action = ACT_ADD_NODE;
      else if (pick < 45) action = ACT_ADD_EDGE;
      else if (pick < 53) action = ACT_SET_SEEN;
      else if (pick < 61) action = ACT_QUERY_SEEN;
      else if (pick < 63) action = ACT_RESET_SEEN;
      else if (pick < 76) action = ACT_NEIGHBOURS;
      else if (pick < 80) action = ACT_IS_EMPTY;
      else if (pick < 84) action = ACT_HAS_EDGES;
      else if (pick < 86) action = ACT_CLEAR;
      else if (pick < 90) action = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else                action = ACT_W'($urandom_range(0, ACT_SPARE_HI));
      send_request(action, pick_node(), pick_node(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_CLEAR;
    req_ch.node_a     <= '0;
    req_ch.node_b     <= '0;
    req_ch.seen_value <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= NODE_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty graph after reset: every node reference is absent.
    send_request(ACT_IS_EMPTY, 6'd0, 6'd0, 1'b0);
    send_request(ACT_HAS_EDGES, 6'd0, 6'd0, 1'b0);
    send_request(ACT_NEIGHBOURS, 6'd0, 6'd0, 1'b0);
    send_request(ACT_ADD_NODE, 6'd63, 6'd63, 1'b1);

    // A limit of two fills the table on the third insert.
    write_limit(7'd2);
    send_request(ACT_ADD_NODE, 6'd0, 6'd0, 1'b0);
    send_request(ACT_ADD_NODE, 6'd0, 6'd0, 1'b0);
    send_request(ACT_ADD_EDGE, 6'd1, 6'd0, 1'b0);
    send_request(ACT_ADD_EDGE, 6'd1, 6'd1, 1'b0);
    send_request(ACT_ADD_EDGE, 6'd0, 6'd63, 1'b0);
    send_request(ACT_ADD_EDGE, 6'd63, 6'd0, 1'b0);
    send_request(ACT_NEIGHBOURS, 6'd1, 6'd0, 1'b0);
    send_request(ACT_NEIGHBOURS, 6'd0, 6'd0, 1'b0);
    send_request(ACT_SET_SEEN, 6'd1, 6'd0, 1'b1);
    send_request(ACT_QUERY_SEEN, 6'd1, 6'd0, 1'b0);
    send_request(ACT_QUERY_SEEN, 6'd63, 6'd0, 1'b0);
    send_request(ACT_SET_SEEN, 6'd63, 6'd0, 1'b1);
    send_request(ACT_RESET_SEEN, 6'd0, 6'd0, 1'b0);
    send_request(ACT_QUERY_SEEN, 6'd1, 6'd0, 1'b0);
    send_request(ACT_HAS_EDGES, 6'd0, 6'd0, 1'b0);
    send_request(ACT_IS_EMPTY, 6'd0, 6'd0, 1'b0);
    send_request(ACT_SPARE_LO, 6'd0, 6'd0, 1'b0);
    send_request(ACT_SPARE_HI, 6'd63, 6'd63, 1'b1);
    send_request(ACT_CLEAR, 6'd0, 6'd0, 1'b0);
    send_request(ACT_IS_EMPTY, 6'd0, 6'd0, 1'b0);
    send_request(ACT_ADD_NODE, 6'd0, 6'd0, 1'b0);

    // A limit above the node capacity acts as the capacity; fill the table, then overrun it.
    write_limit(7'd127);
    repeat (70) begin
      send_request(ACT_ADD_NODE, NODE_W'($urandom), NODE_W'($urandom), 1'($urandom_range(0, 1)));
    end
    run_random(100);

    // Lowering the limit below the count keeps the nodes already there.
    write_limit(7'd9);
    run_random(60);

    // A zero limit refuses every insert.
    write_limit(7'd0);
    run_random(40);

    // Full limit with both sides running without gaps.
    write_limit(7'd64);
    steady = 1'b1;
    run_random(100);
    steady = 1'b0;

    write_limit(LIMIT_W'($urandom_range(1, NODES)));
    run_random(50);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS adjacency_matrix_graph_store_top");
    end else begin
      $display("FAIL adjacency_matrix_graph_store_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/amg_pkg.sv
hdl/amg_req_if.sv
hdl/amg_rsp_if.sv
hdl/amg_cfg_if.sv
hdl/amg_ram.sv
hdl/amg_nbr_scan.sv
hdl/adjacency_matrix_graph_store_top.sv
tb/sv/tb_top.sv
